[sv/vefq_pkg.sv]
// Shared types and constants for the voxel exposed-face query core.
// Used by vefq_ctrl, vefq_datapath and voxel_exposed_face_query_core.
package vefq_pkg;

   // Field widths of the request and response transactions
   localparam int OPCODE_W = 1;
   localparam int POS_X_W  = 3;
   localparam int POS_Y_W  = 3;
   localparam int POS_Z_W  = 5;
   localparam int COLOR_W  = 2;
   localparam int MASK_W   = 6;
   localparam int COUNT_W  = 3;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 16;

   // Largest coordinate a neighbor can take (one past the field range)
   localparam int NBR_X_MAX = 8;
   localparam int NBR_Y_MAX = 8;
   localparam int NBR_Z_MAX = 32;

   localparam int NBR_X_W = 4;
   localparam int NBR_Y_W = 4;
   localparam int NBR_Z_W = 6;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

   localparam logic [COLOR_W-1:0] COLOR_EMPTY = 2'd0;

   // Lookup sequence: center first, then the six neighbors
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
   localparam logic [STEP_W-1:0] STEP_LEFT   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_RIGHT  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_TOP    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_BOTTOM = 3'd4;
   localparam logic [STEP_W-1:0] STEP_FRONT  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_BACK   = 3'd6;

   // Bit positions in the face mask
   localparam int FACE_LEFT   = 0;
   localparam int FACE_RIGHT  = 1;
   localparam int FACE_TOP    = 2;
   localparam int FACE_BOTTOM = 3;
   localparam int FACE_FRONT  = 4;
   localparam int FACE_BACK   = 5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_LOOKUP,
      ST_DRAIN,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic clear;    // zero one store entry
      logic load;     // capture the request transaction
      logic write;    // store the captured color
      logic lookup;   // issue one store read of the lookup sequence
      logic publish;  // move the finished result into the response register
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;  // last entry of the clearing pass
      logic step_last;   // back neighbor is being read
      logic out_free;    // response register can take a result this cycle
   } dp_status_type;

endpackage

[sv/voxel_exposed_face_query_core.sv]
// Voxel exposed-face query core, top level.
// Instantiates vefq_ctrl and vefq_datapath; types from vefq_pkg.
//
// Request channel (req_*): one transaction per command. req_tuser is the
// opcode: write stores a 2-bit color at (x, y, z) and returns nothing; query
// returns the voxel color, the 6-bit exposed-face mask and its bit count on
// the response channel (rsp_*).
// Sequence: a write stores its color and returns the core to idle. A query
// reads the single-port voxel store once per cycle for the voxel and its six
// neighbors, then drains the read data and loads the result into the
// response register. The next command is accepted only once the previous
// write is stored or the previous query result is loaded.
// Reset: the store is swept to empty, one entry per cycle, through all
// VOXEL_COUNT entries (2048 by default); req_tready stays low during the sweep.
// Stall: the response register holds a finished result while rsp_tready is
// low; the next command is still accepted and worked on, and only its
// result load waits until the register frees.
module voxel_exposed_face_query_core #(
   parameter int GRID_WIDTH  = 8,
   parameter int GRID_HEIGHT = 8,
   parameter int GRID_DEPTH  = 32,
   parameter int VOXEL_COUNT = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // bits: [2:0] pos_x, [5:3] pos_y, [10:6] pos_z, [12:11] new_color, zero pad
   input  logic [vefq_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // bit 0: opcode
   input  logic [vefq_pkg::OPCODE_W-1:0]        req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // bits: [1:0] voxel_color, [7:2] face_mask, [10:8] face_count, zero pad
   output logic [vefq_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int X_LO = 0;
   localparam int Y_LO = X_LO + vefq_pkg::POS_X_W;
   localparam int Z_LO = Y_LO + vefq_pkg::POS_Y_W;
   localparam int C_LO = Z_LO + vefq_pkg::POS_Z_W;
   localparam int RSP_USED = vefq_pkg::COLOR_W + vefq_pkg::MASK_W + vefq_pkg::COUNT_W;

   vefq_pkg::dp_cmd_type    cmd;
   vefq_pkg::dp_status_type status;

   logic [vefq_pkg::COLOR_W-1:0] rsp_voxel_color;
   logic [vefq_pkg::MASK_W-1:0]  rsp_face_mask;
   logic [vefq_pkg::COUNT_W-1:0] rsp_face_count;

   vefq_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_is_query (req_tuser == vefq_pkg::OP_QUERY),
      .status       (status),
      .cmd          (cmd)
   );

   vefq_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .GRID_DEPTH  (GRID_DEPTH),
      .VOXEL_COUNT (VOXEL_COUNT)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pos_x       (req_tdata[X_LO +: vefq_pkg::POS_X_W]),
      .req_pos_y       (req_tdata[Y_LO +: vefq_pkg::POS_Y_W]),
      .req_pos_z       (req_tdata[Z_LO +: vefq_pkg::POS_Z_W]),
      .req_new_color   (req_tdata[C_LO +: vefq_pkg::COLOR_W]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_voxel_color (rsp_voxel_color),
      .rsp_face_mask   (rsp_face_mask),
      .rsp_face_count  (rsp_face_count)
   );

   assign rsp_tdata = {{(vefq_pkg::RSP_TDATA_W - RSP_USED){1'b0}},
                       rsp_face_count, rsp_face_mask, rsp_voxel_color};

endmodule

[sv/vefq_ctrl.sv]
// Controller for the voxel exposed-face query core: sequences clearing,
// writes, lookups and result hand-off. Uses vefq_pkg types.
module vefq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_is_query,
   input  vefq_pkg::dp_status_type status,
   output vefq_pkg::dp_cmd_type    cmd
);

   vefq_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vefq_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vefq_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = vefq_pkg::ST_IDLE;
         end
         vefq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = req_is_query ? vefq_pkg::ST_LOOKUP : vefq_pkg::ST_WRITE;
            end
         end
         vefq_pkg::ST_WRITE: begin
            state_in = vefq_pkg::ST_IDLE;
         end
         vefq_pkg::ST_LOOKUP: begin
            if (status.step_last) state_in = vefq_pkg::ST_DRAIN;
         end
         vefq_pkg::ST_DRAIN: begin
            state_in = vefq_pkg::ST_RESULT;
         end
         vefq_pkg::ST_RESULT: begin
            if (status.out_free) state_in = vefq_pkg::ST_IDLE;
         end
         default: begin
            state_in = vefq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         vefq_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         vefq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         vefq_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
         end
         vefq_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         vefq_pkg::ST_RESULT: begin
            cmd.publish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[sv/vefq_datapath.sv]
// Datapath for the voxel exposed-face query core: request registers, voxel
// store, neighbor address generation, face accumulation and response register.
module vefq_datapath #(
   parameter int GRID_WIDTH  = 8,
   parameter int GRID_HEIGHT = 8,
   parameter int GRID_DEPTH  = 32,
   parameter int VOXEL_COUNT = 2048
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  vefq_pkg::dp_cmd_type                 cmd,
   output vefq_pkg::dp_status_type              status,
   input  logic [vefq_pkg::POS_X_W-1:0]         req_pos_x,
   input  logic [vefq_pkg::POS_Y_W-1:0]         req_pos_y,
   input  logic [vefq_pkg::POS_Z_W-1:0]         req_pos_z,
   input  logic [vefq_pkg::COLOR_W-1:0]         req_new_color,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [vefq_pkg::COLOR_W-1:0]         rsp_voxel_color,
   output logic [vefq_pkg::MASK_W-1:0]          rsp_face_mask,
   output logic [vefq_pkg::COUNT_W-1:0]         rsp_face_count
);

   localparam int ADDR_W   = (VOXEL_COUNT > 1) ? $clog2(VOXEL_COUNT) : 1;
   localparam int SLOT_MAX = vefq_pkg::NBR_X_MAX + vefq_pkg::NBR_Y_MAX * GRID_WIDTH
                             + vefq_pkg::NBR_Z_MAX * GRID_WIDTH * GRID_HEIGHT;
   localparam int SLOT_W   = $clog2(SLOT_MAX + 1);
   localparam int EXT_W    = (SLOT_W > ADDR_W) ? SLOT_W : ADDR_W;
   localparam int LAYER    = GRID_WIDTH * GRID_HEIGHT;

   logic [vefq_pkg::COLOR_W-1:0] mem [VOXEL_COUNT];

   logic [vefq_pkg::POS_X_W-1:0]  x_ff;
   logic [vefq_pkg::POS_Y_W-1:0]  y_ff;
   logic [vefq_pkg::POS_Z_W-1:0]  z_ff;
   logic [vefq_pkg::COLOR_W-1:0]  color_ff;
   logic [vefq_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [ADDR_W-1:0]             clr_cnt_ff, clr_cnt_in;

   logic [vefq_pkg::NBR_X_W-1:0]  nbr_x;
   logic [vefq_pkg::NBR_Y_W-1:0]  nbr_y;
   logic [vefq_pkg::NBR_Z_W-1:0]  nbr_z;
   logic                          on_edge;
   logic                          in_grid;
   logic [EXT_W-1:0]              slot;
   logic                          beyond;
   logic                          skip;
   logic [ADDR_W-1:0]             addr;

   logic [vefq_pkg::COLOR_W-1:0]  rd_data_ff;
   logic                          lk_valid_ff;
   logic [vefq_pkg::STEP_W-1:0]   lk_step_ff;
   logic                          lk_skip_ff;
   logic                          lk_empty;

   logic [vefq_pkg::COLOR_W-1:0]  acc_color_ff;
   logic [vefq_pkg::MASK_W-1:0]   acc_mask_ff;
   logic [vefq_pkg::MASK_W-1:0]   final_mask;
   logic [vefq_pkg::COUNT_W-1:0]  final_count;

   logic                          rsp_valid_ff;
   logic [vefq_pkg::COLOR_W-1:0]  rsp_color_ff;
   logic [vefq_pkg::MASK_W-1:0]   rsp_mask_ff;
   logic [vefq_pkg::COUNT_W-1:0]  rsp_count_ff;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         z_ff     <= req_pos_z;
         color_ff <= req_new_color;
      end
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.load) begin
         step_in = vefq_pkg::STEP_CENTER;
      end else if (cmd.lookup) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (cmd.clear) clr_cnt_in = clr_cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= vefq_pkg::STEP_CENTER;
         clr_cnt_ff <= '0;
      end else begin
         step_ff    <= step_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign in_grid = (32'(x_ff) < GRID_WIDTH) && (32'(y_ff) < GRID_HEIGHT)
                    && (32'(z_ff) < GRID_DEPTH);

   // Coordinate and grid-edge test for the current lookup step
   always_comb begin
      nbr_x   = vefq_pkg::NBR_X_W'(x_ff);
      nbr_y   = vefq_pkg::NBR_Y_W'(y_ff);
      nbr_z   = vefq_pkg::NBR_Z_W'(z_ff);
      on_edge = 1'b0;
      case (step_ff)
         vefq_pkg::STEP_CENTER: begin
            on_edge = !in_grid;
         end
         vefq_pkg::STEP_LEFT: begin
            nbr_x   = vefq_pkg::NBR_X_W'(x_ff) - 1'b1;
            on_edge = (x_ff == '0);
         end
         vefq_pkg::STEP_RIGHT: begin
            nbr_x   = vefq_pkg::NBR_X_W'(x_ff) + 1'b1;
            on_edge = (32'(x_ff) == GRID_WIDTH - 1);
         end
         vefq_pkg::STEP_TOP: begin
            nbr_y   = vefq_pkg::NBR_Y_W'(y_ff) - 1'b1;
            on_edge = (y_ff == '0);
         end
         vefq_pkg::STEP_BOTTOM: begin
            nbr_y   = vefq_pkg::NBR_Y_W'(y_ff) + 1'b1;
            on_edge = (32'(y_ff) == GRID_HEIGHT - 1);
         end
         vefq_pkg::STEP_FRONT: begin
            nbr_z   = vefq_pkg::NBR_Z_W'(z_ff) - 1'b1;
            on_edge = (z_ff == '0);
         end
         vefq_pkg::STEP_BACK: begin
            nbr_z   = vefq_pkg::NBR_Z_W'(z_ff) + 1'b1;
            on_edge = (32'(z_ff) == GRID_DEPTH - 1);
         end
         default: begin
            on_edge = 1'b1;
         end
      endcase
   end

   // Constant multipliers only; a slot past the store end reads as empty
   assign slot   = EXT_W'(nbr_x) + EXT_W'(nbr_y) * EXT_W'(GRID_WIDTH)
                   + EXT_W'(nbr_z) * EXT_W'(LAYER);
   assign beyond = (32'(slot) >= VOXEL_COUNT);
   assign skip   = on_edge || beyond;
   assign addr   = slot[ADDR_W-1:0];

   // Voxel store: single port, registered read
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem[clr_cnt_ff] <= vefq_pkg::COLOR_EMPTY;
      end else if (cmd.write && !skip) begin
         mem[addr] <= color_ff;
      end
      if (cmd.lookup && !beyond) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lk_valid_ff <= 1'b0;
      end else begin
         lk_valid_ff <= cmd.lookup;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         lk_step_ff <= step_ff;
         lk_skip_ff <= skip;
      end
   end

   assign lk_empty = lk_skip_ff || (rd_data_ff == vefq_pkg::COLOR_EMPTY);

   // Face accumulation, one read result per cycle
   always_ff @(posedge clock) begin
      if (lk_valid_ff) begin
         case (lk_step_ff)
            vefq_pkg::STEP_CENTER: begin
               acc_color_ff <= lk_skip_ff ? vefq_pkg::COLOR_EMPTY : rd_data_ff;
            end
            vefq_pkg::STEP_LEFT:   acc_mask_ff[vefq_pkg::FACE_LEFT]   <= lk_empty;
            vefq_pkg::STEP_RIGHT:  acc_mask_ff[vefq_pkg::FACE_RIGHT]  <= lk_empty;
            vefq_pkg::STEP_TOP:    acc_mask_ff[vefq_pkg::FACE_TOP]    <= lk_empty;
            vefq_pkg::STEP_BOTTOM: acc_mask_ff[vefq_pkg::FACE_BOTTOM] <= lk_empty;
            vefq_pkg::STEP_FRONT:  acc_mask_ff[vefq_pkg::FACE_FRONT]  <= lk_empty;
            vefq_pkg::STEP_BACK:   acc_mask_ff[vefq_pkg::FACE_BACK]   <= lk_empty;
            default: begin
               acc_color_ff <= acc_color_ff;
            end
         endcase
      end
   end

   // An empty voxel exposes nothing
   always_comb begin
      final_mask  = (acc_color_ff == vefq_pkg::COLOR_EMPTY) ? '0 : acc_mask_ff;
      final_count = '0;
      for (int i = 0; i < vefq_pkg::MASK_W; i++) begin
         final_count = final_count + vefq_pkg::COUNT_W'(final_mask[i]);
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_color_ff <= acc_color_ff;
         rsp_mask_ff  <= final_mask;
         rsp_count_ff <= final_count;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_voxel_color = rsp_color_ff;
   assign rsp_face_mask   = rsp_mask_ff;
   assign rsp_face_count  = rsp_count_ff;

   assign status.clear_last = (clr_cnt_ff == ADDR_W'(VOXEL_COUNT - 1));
   assign status.step_last  = (step_ff == vefq_pkg::STEP_BACK);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

endmodule
